// ----- rtl/apsf_pkg.sv -----
// apsf_pkg: shared constants, register codes, fsm states and the alpha table
// function for the adaptive power smoothing filter
// no dependencies
`timescale 1ns / 1ps

package apsf_pkg;

  localparam int DefPowerBits  = 24;
  localparam int DefAlphaDepth = 256;

  localparam int FastDeltaW = 23;
  localparam int TauW       = 16;
  localparam int FirstDtW   = 11;
  localparam int CfgW       = 23;
  localparam int CfgIdxW    = 2;

  localparam logic [FastDeltaW-1:0] FastDeltaRst = FastDeltaW'(2000);
  localparam logic [TauW-1:0]       FastTauRst   = TauW'(300);
  localparam logic [TauW-1:0]       SmoothTauRst = TauW'(2000);
  localparam logic [FirstDtW-1:0]   FirstDtRst   = FirstDtW'(250);

  localparam int DtW          = 11;
  localparam int DtMax        = 2000;
  localparam int MinMagnitude = 100;

  localparam int              AlphaW   = 17;
  localparam logic [AlphaW-1:0] AlphaOne = AlphaW'(65536);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FAST_DELTA = 2'd0,
    CFG_FAST_TAU   = 2'd1,
    CFG_SMOOTH_TAU = 2'd2,
    CFG_FIRST_DT   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_DIV,
    ST_MST,
    ST_MUL,
    ST_OUT
  } state_e;

  // alpha = 1 - exp(-x) at the midpoint of table entry idx, Q1.16
  function automatic logic [AlphaW-1:0] alpha_at(input logic [63:0] y, input int idx);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] full;
    term = 64'd1 << 32;
    pos  = term;
    neg  = '0;
    for (int k = 1; k < 20; k++) begin
      if (term != '0) begin
        term = ((term * y) >> 32) / 64'(k);
        if (k[0]) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
    end
    s = pos - neg;
    r = (s * s + (64'd1 << 31)) >> 32;
    e = s;
    for (int i = 1; i <= idx; i++) begin
      e = (e * r + (64'd1 << 31)) >> 32;
    end
    full = ((64'd1 << 32) - e + 64'd32768) >> 16;
    return full[AlphaW-1:0];
  endfunction

endpackage

// ----- rtl/apsf_if.sv -----
// apsf_in_if / apsf_out_if: valid-ready channels for samples and results
// no dependencies
`timescale 1ns / 1ps

interface apsf_in_if #(
  parameter int POWER_BITS = 24
) ();
  logic                         valid;
  logic                         ready;
  logic signed [POWER_BITS-1:0] power_sample;
  logic [1:0]                   power_dir;
  logic [31:0]                  now_ms;

  modport source (output valid, output power_sample, output power_dir, output now_ms,
                  input ready);
  modport sink (input valid, input power_sample, input power_dir, input now_ms,
                output ready);
endinterface

interface apsf_out_if #(
  parameter int POWER_BITS = 24
) ();
  logic                         valid;
  logic                         ready;
  logic signed [POWER_BITS-1:0] smoothed_power;

  modport source (output valid, output smoothed_power, input ready);
  modport sink (input valid, input smoothed_power, output ready);
endinterface

// ----- rtl/adaptive_power_smoothing_filter_core.sv -----
// adaptive_power_smoothing_filter_core: top level, control fsm, filter state
// depends on apsf_pkg, apsf_if, apsf_div, apsf_mul, apsf_lut
`timescale 1ns / 1ps

// usage
// - in_i beats carry power_sample, power_dir and now_ms; out_o returns one
//   smoothed_power beat for every input beat, in order
// - cfg_we_i/cfg_idx_i/cfg_wdata_i write fast_delta, fast_tau_ms,
//   smooth_tau_ms and first_dt_ms; write only while the block is idle
// - one beat is processed at a time; in_i.ready is high while no beat is at work
// - idle, small-magnitude and seeding beats: decode, then the result goes to the output
// - filtering beats: elapsed time over tau by a bit-serial divider, then a
//   table read, then alpha times distance by a shift-add multiplier
// - the result sits in an output register, so a new beat is accepted while
//   the receiver stalls; the block then waits to hand over its next result
// - reset clears the filter state and loads the default register values;
//   no clearing pass is needed
module adaptive_power_smoothing_filter_core
  import apsf_pkg::*;
#(
  parameter int POWER_BITS        = DefPowerBits,
  parameter int ALPHA_TABLE_DEPTH = DefAlphaDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  apsf_in_if.sink            in_i,
  apsf_out_if.source         out_o
);

  localparam int NumW = $clog2(DtMax * ALPHA_TABLE_DEPTH + 1);
  localparam int DenW = TauW + 3;
  localparam int PW   = AlphaW + POWER_BITS;

  state_e state_q, state_d;

  logic [FastDeltaW-1:0] fast_delta_q;
  logic [TauW-1:0]       fast_tau_q;
  logic [TauW-1:0]       smooth_tau_q;
  logic [FirstDtW-1:0]   first_dt_q;

  logic                         armed_q, armed_d;
  logic [1:0]                   held_dir_q, held_dir_d;
  logic signed [POWER_BITS-1:0] filt_q, filt_d;
  logic [31:0]                  last_q, last_d;

  logic signed [POWER_BITS-1:0] samp_q;
  logic [1:0]                   dir_q;
  logic [31:0]                  now_q;
  logic [POWER_BITS-1:0]        mag_q;
  logic                         neg_q;
  logic signed [POWER_BITS-1:0] res_q, res_d;
  logic                         out_valid_q, out_valid_d;
  logic signed [POWER_BITS-1:0] out_data_q;

  logic in_ready, div_start, lut_load, mul_start, out_load, slot_free;
  logic zero_case, take_filter;

  logic [31:0]           dt_raw;
  logic [DtW-1:0]        dt;
  logic [NumW-1:0]       num;
  logic [POWER_BITS:0]   diff;
  logic [POWER_BITS:0]   diff_abs;
  logic [POWER_BITS-1:0] mag;
  logic                  fast_sel;
  logic [TauW-1:0]       tau_sel;
  logic [TauW-1:0]       tau_eff;
  logic [DenW-1:0]       den;

  logic              div_done;
  logic [NumW-1:0]   quot;
  logic [AlphaW-1:0] alpha;
  logic              mul_done;
  logic [PW-1:0]     prod;
  logic [PW-1:0]     prod_rnd;
  logic [POWER_BITS-1:0] step;

  // classification of the latched beat
  assign zero_case = (dir_q == 2'd0)
                   || ((int'(samp_q) > -MinMagnitude) && (int'(samp_q) < MinMagnitude));
  assign take_filter = !zero_case && armed_q && (held_dir_q == dir_q);

  // elapsed time
  assign dt_raw = (last_q == '0) ? 32'(first_dt_q) : (now_q - last_q);
  assign dt = (dt_raw == '0) ? DtW'(1)
            : (dt_raw > 32'(DtMax)) ? DtW'(DtMax) : dt_raw[DtW-1:0];
  assign num = NumW'(32'(dt) * 32'(ALPHA_TABLE_DEPTH));

  // distance and time constant
  assign diff     = {samp_q[POWER_BITS-1], samp_q} - {filt_q[POWER_BITS-1], filt_q};
  assign diff_abs = diff[POWER_BITS] ? (~diff + (POWER_BITS+1)'(1)) : diff;
  assign mag      = diff_abs[POWER_BITS-1:0];
  assign fast_sel = (FastDeltaW + POWER_BITS)'(mag) >= (FastDeltaW + POWER_BITS)'(fast_delta_q);
  assign tau_sel  = fast_sel ? fast_tau_q : smooth_tau_q;
  assign tau_eff  = (tau_sel == '0) ? TauW'(1) : tau_sel;
  assign den      = {tau_eff, 3'b000};

  // rounded step
  assign prod_rnd = prod + PW'(32768);
  assign step     = prod_rnd[16 +: POWER_BITS];

  apsf_div #(
    .NumW (NumW),
    .DenW (DenW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  apsf_lut #(
    .ALPHA_TABLE_DEPTH (ALPHA_TABLE_DEPTH),
    .NumW              (NumW)
  ) u_lut (
    .clk_i   (clk_i),
    .load_i  (lut_load),
    .idx_i   (quot),
    .alpha_o (alpha)
  );

  apsf_mul #(
    .AW (AlphaW),
    .BW (POWER_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (alpha),
    .b_i     (mag_q),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  assign slot_free = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_i.valid) state_d = ST_DEC;
      ST_DEC:  state_d = take_filter ? ST_DIV : ST_OUT;
      ST_DIV:  if (div_done) state_d = ST_MST;
      ST_MST:  state_d = ST_MUL;
      ST_MUL:  if (mul_done) state_d = ST_OUT;
      ST_OUT:  if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    lut_load  = 1'b0;
    mul_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_DEC:  div_start = take_filter;
      ST_DIV:  lut_load = div_done;
      ST_MST:  mul_start = 1'b1;
      ST_MUL:  ;
      ST_OUT:  out_load = slot_free;
      default: ;
    endcase
  end

  // filter state update
  always_comb begin
    armed_d    = armed_q;
    held_dir_d = held_dir_q;
    filt_d     = filt_q;
    last_d     = last_q;
    res_d      = res_q;
    if (state_q == ST_DEC) begin
      armed_d    = 1'b1;
      held_dir_d = dir_q;
      last_d     = now_q;
      if (zero_case) begin
        filt_d = '0;
        res_d  = '0;
      end else if (!take_filter) begin
        filt_d = samp_q;
        res_d  = samp_q;
      end
    end else if ((state_q == ST_MUL) && mul_done) begin
      filt_d = neg_q ? (filt_q - step) : (filt_q + step);
      res_d  = filt_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fast_delta_q <= FastDeltaRst;
      fast_tau_q   <= FastTauRst;
      smooth_tau_q <= SmoothTauRst;
      first_dt_q   <= FirstDtRst;
      armed_q      <= 1'b0;
      held_dir_q   <= 2'd0;
      filt_q       <= '0;
      last_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      armed_q     <= armed_d;
      held_dir_q  <= held_dir_d;
      filt_q      <= filt_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_FAST_DELTA: fast_delta_q <= cfg_wdata_i[FastDeltaW-1:0];
          CFG_FAST_TAU:   fast_tau_q   <= cfg_wdata_i[TauW-1:0];
          CFG_SMOOTH_TAU: smooth_tau_q <= cfg_wdata_i[TauW-1:0];
          CFG_FIRST_DT:   first_dt_q   <= cfg_wdata_i[FirstDtW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      samp_q <= in_i.power_sample;
      dir_q  <= in_i.power_dir;
      now_q  <= in_i.now_ms;
    end
    if (div_start) begin
      mag_q <= mag;
      neg_q <= diff[POWER_BITS];
    end
    res_q <= res_d;
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.smoothed_power = out_data_q;

endmodule

// ----- rtl/apsf_div.sv -----
// apsf_div: restoring bit-serial divider, one quotient bit per cycle
// depends on nothing beyond its parameters
`timescale 1ns / 1ps

module apsf_div #(
  parameter int NumW = 21,
  parameter int DenW = 19
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);

  localparam int CntW = (NumW > 1) ? $clog2(NumW) : 1;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   trial;
  logic            ge;

  assign trial = {rem_q, num_q[NumW-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      num_d = {num_q[NumW-2:0], ge};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ----- rtl/apsf_mul.sv -----
// apsf_mul: shift-add multiplier, one multiplier bit per cycle
// depends on nothing beyond its parameters
`timescale 1ns / 1ps

module apsf_mul #(
  parameter int AW = 17,
  parameter int BW = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             done_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int PW   = AW + BW;
  localparam int CntW = (AW > 1) ? $clog2(AW) : 1;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AW-1:0]   mplier_q, mplier_d;
  logic [PW-1:0]   mcand_q, mcand_d;
  logic [PW-1:0]   acc_q, acc_d;

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    mplier_d = mplier_q;
    mcand_d  = mcand_q;
    acc_d    = acc_q;
    if (start_i) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      mplier_d = a_i;
      mcand_d  = PW'(b_i);
      acc_d    = '0;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = {mcand_q[PW-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[AW-1:1]};
      cnt_d    = cnt_q + CntW'(1);
      if (cnt_q == CntW'(AW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mplier_q <= mplier_d;
    mcand_q  <= mcand_d;
    acc_q    <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ----- rtl/apsf_lut.sv -----
// apsf_lut: alpha table lookup with saturation to one, registered output
// depends on apsf_pkg for the table function
`timescale 1ns / 1ps

module apsf_lut
  import apsf_pkg::*;
#(
  parameter int ALPHA_TABLE_DEPTH = DefAlphaDepth,
  parameter int NumW              = 21
) (
  input  logic              clk_i,
  input  logic              load_i,
  input  logic [NumW-1:0]   idx_i,
  output logic [AlphaW-1:0] alpha_o
);

  localparam int          IdxW   = $clog2(ALPHA_TABLE_DEPTH);
  localparam logic [63:0] AlphaY = (64'd4 << 32) / ALPHA_TABLE_DEPTH;

  logic [AlphaW-1:0] rom [ALPHA_TABLE_DEPTH];
  logic [AlphaW-1:0] alpha_q, alpha_d;

  for (genvar g = 0; g < ALPHA_TABLE_DEPTH; g++) begin : g_rom
    assign rom[g] = alpha_at(AlphaY, g);
  end

  always_comb begin
    alpha_d = alpha_q;
    if (load_i) begin
      alpha_d = (idx_i >= NumW'(ALPHA_TABLE_DEPTH)) ? AlphaOne : rom[idx_i[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    alpha_q <= alpha_d;
  end

  assign alpha_o = alpha_q;

endmodule
